/* sv/pid_controller_filtered_derivative_macros.svh */
// assertion macros shared by the pid controller checker
// depends on a clock named i_clk and an active low reset named i_rst_n in the using scope
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_MACROS_SVH

// consequence must hold in the same cycle
`define PIDFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidfd check failed");

// consequence must hold in the next cycle
`define PIDFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidfd check failed");

`endif

/* sv/pidfd_pkg.sv */
// shared types and constants of the pid controller
// no dependencies
`timescale 1ns / 1ps

package pidfd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_PROP    = 3'd0;
    localparam logic [2:0] CFG_GAIN_INTEG   = 3'd1;
    localparam logic [2:0] CFG_GAIN_DERIV   = 3'd2;
    localparam logic [2:0] CFG_FILTER_TAU   = 3'd3;
    localparam logic [2:0] CFG_OUT_MIN      = 3'd4;
    localparam logic [2:0] CFG_OUT_MAX      = 3'd5;
    localparam logic [2:0] CFG_DEADBAND_POS = 3'd6;
    localparam logic [2:0] CFG_DEADBAND_NEG = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ERR, ST_MP, ST_P, ST_T, ST_MI, ST_ACC, ST_CLAMP, ST_MD, ST_M1,
        ST_NUM, ST_DSET, ST_DIV, ST_DF, ST_SUM, ST_MY, ST_DSET2, ST_DIV2, ST_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ERR, OP_MP, OP_P, OP_T, OP_MI, OP_ACC, OP_CLAMP, OP_MD,
        OP_M1, OP_NUM, OP_DSET, OP_DIV, OP_DF, OP_SUM, OP_MY, OP_DSET2, OP_FIN
    } t_op;

    typedef struct packed {
        logic den_zero;
        logic div_last;
        logic remap;
    } t_dp_stat;

endpackage

/* sv/pidfd_ctrl.sv */
// sequencer of the pid controller: steps the datapath through one sample
// depends on pidfd_pkg
`timescale 1ns / 1ps

module pidfd_ctrl
    import pidfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_op      o_op
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid & i_stall;
        o_op    = OP_NONE;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_op    = OP_LOAD;
                    n_state = ST_ERR;
                end
            end
            ST_ERR:   begin o_op = OP_ERR;   n_state = ST_MP;    end
            ST_MP:    begin o_op = OP_MP;    n_state = ST_P;     end
            ST_P:     begin o_op = OP_P;     n_state = ST_T;     end
            ST_T:     begin o_op = OP_T;     n_state = ST_MI;    end
            ST_MI:    begin o_op = OP_MI;    n_state = ST_ACC;   end
            ST_ACC:   begin o_op = OP_ACC;   n_state = ST_CLAMP; end
            ST_CLAMP: begin o_op = OP_CLAMP; n_state = ST_MD;    end
            ST_MD:    begin o_op = OP_MD;    n_state = ST_M1;    end
            ST_M1:    begin o_op = OP_M1;    n_state = ST_NUM;   end
            ST_NUM: begin
                o_op    = OP_NUM;
                n_state = i_stat.den_zero ? ST_SUM : ST_DSET;
            end
            ST_DSET:  begin o_op = OP_DSET;  n_state = ST_DIV;   end
            ST_DIV: begin
                o_op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = ST_DF;
                end
            end
            ST_DF:    begin o_op = OP_DF;    n_state = ST_SUM;   end
            ST_SUM:   begin o_op = OP_SUM;   n_state = ST_MY;    end
            ST_MY: begin
                if (i_stat.remap) begin
                    o_op    = OP_MY;
                    n_state = ST_DSET2;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DSET2: begin o_op = OP_DSET2; n_state = ST_DIV2;  end
            ST_DIV2: begin
                o_op = OP_DIV;
                if (i_stat.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!(r_valid && i_stall)) begin
                    o_op    = OP_FIN;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_valid;

endmodule

/* sv/pidfd_dp.sv */
// datapath of the pid controller: registers, shared multiplier, serial divider
// depends on pidfd_pkg
`timescale 1ns / 1ps

module pidfd_dp
    import pidfd_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [W-1:0]        i_cfg_data,
    input  logic signed [W-1:0] i_target,
    input  logic signed [W-1:0] i_sensed,
    input  logic [W-2:0]        i_step_time,
    input  t_op                 i_op,
    output t_dp_stat            o_stat,
    output logic signed [W-1:0] o_drive
);

    localparam int WD = 2 * W + 4;
    localparam int DV = 2 * W + 3;
    localparam int DW = W + 1;
    localparam int CW = $clog2(DV + 1);
    localparam logic signed [WD-1:0] VMAX_X = $signed({{(WD-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [WD-1:0] VMIN_X = -VMAX_X - 1;

    function automatic logic signed [W-1:0] sat_w(input logic signed [WD-1:0] v);
        logic signed [WD-1:0] c;
        c = v;
        if (v > VMAX_X) c = VMAX_X;
        if (v < VMIN_X) c = VMIN_X;
        return c[W-1:0];
    endfunction

    // configuration
    logic signed [W-1:0] r_gp, r_gi, r_gd, r_omin;
    logic [W-2:0]        r_tau, r_omax, r_dbp, r_dbn;
    // sample and loop state
    logic signed [W-1:0] r_tgt, r_sen, r_integ, r_dfilt, r_lerr, r_lsen;
    logic [W-2:0]        r_stp;
    // working registers
    logic signed [W-1:0]   r_err, r_delta, r_prop, r_t, r_y, r_drive;
    logic [W:0]            r_den;
    logic signed [W:0]     r_k, r_hi, r_lo, r_add;
    logic signed [2*W+1:0] r_prod;
    logic signed [WD-1:0]  r_acc, r_num;
    logic [DV-1:0]         r_dvd;
    logic [DW-1:0]         r_rem, r_dvs;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;

    logic signed [W:0]     ma, mb, omax_x, omin_x, prop_x, scale;
    logic signed [2*W+1:0] prod_c, prod_mag;
    logic signed [WD-1:0]  sh_f, sh_f1, tv, ys, num_mag, num_shl, quo_s, clip;
    logic [DW:0]           rem_sh, rem_nx;
    logic                  ge, y_pos, y_neg;

    assign omax_x = $signed({2'b00, r_omax});
    assign omin_x = (W+1)'(r_omin);
    assign prop_x = (W+1)'(r_prop);
    assign y_pos  = !r_y[W-1] && (r_y != '0);
    assign y_neg  = r_y[W-1];
    assign scale  = y_pos ? omax_x - $signed({2'b00, r_dbp})
                          : omin_x + $signed({2'b00, r_dbn});

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_op)
            OP_MP: begin ma = (W+1)'(r_gp); mb = (W+1)'(r_err); end
            OP_P:  begin ma = (W+1)'(r_gi); mb = $signed({2'b00, r_stp}); end
            OP_MI: begin ma = (W+1)'(r_t);  mb = (W+1)'(r_err) + (W+1)'(r_lerr); end
            OP_MD: begin ma = (W+1)'(r_gd); mb = (W+1)'(r_delta); end
            OP_M1: begin ma = r_k;          mb = (W+1)'(r_dfilt); end
            OP_MY: begin ma = (W+1)'(r_y);  mb = scale; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod_c   = ma * mb;
    assign sh_f     = WD'(r_prod >>> F);
    assign sh_f1    = WD'(r_prod >>> (F + 1));
    assign tv       = sh_f;
    assign num_mag  = r_num[WD-1] ? -r_num : r_num;
    assign num_shl  = num_mag << F;
    assign prod_mag = r_prod[2*W+1] ? -r_prod : r_prod;
    assign quo_s    = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[DV-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;

    always_comb begin
        ys = WD'(r_prop) + WD'(r_integ) + WD'(r_dfilt);
        if (ys > WD'(omax_x)) ys = WD'(omax_x);
        if (ys < WD'(r_omin)) ys = WD'(r_omin);
    end

    always_comb begin
        clip = r_acc;
        if (r_acc > WD'(r_hi)) begin
            clip = WD'(r_hi);
        end else if (r_acc < WD'(r_lo)) begin
            clip = WD'(r_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_omin  <= '0;
            r_tau   <= '0;
            r_omax  <= '0;
            r_dbp   <= '0;
            r_dbn   <= '0;
            r_integ <= '0;
            r_dfilt <= '0;
            r_lerr  <= '0;
            r_lsen  <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_PROP:    r_gp   <= i_cfg_data;
                    CFG_GAIN_INTEG:   r_gi   <= i_cfg_data;
                    CFG_GAIN_DERIV:   r_gd   <= i_cfg_data;
                    CFG_FILTER_TAU:   r_tau  <= i_cfg_data[W-2:0];
                    CFG_OUT_MIN:      r_omin <= i_cfg_data;
                    CFG_OUT_MAX:      r_omax <= i_cfg_data[W-2:0];
                    CFG_DEADBAND_POS: r_dbp  <= i_cfg_data[W-2:0];
                    CFG_DEADBAND_NEG: r_dbn  <= i_cfg_data[W-2:0];
                    default: ;
                endcase
            end
            case (i_op)
                OP_DSET, OP_DSET2: r_cnt <= CW'(DV);
                OP_DIV:            r_cnt <= r_cnt - 1'b1;
                OP_CLAMP:          r_integ <= sat_w(clip);
                OP_DF:             r_dfilt <= sat_w(quo_s);
                OP_FIN: begin
                    r_lerr <= r_err;
                    r_lsen <= r_sen;
                end
                default: ;
            endcase
        end
    end

    // payload path, no reset
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_tgt <= i_target;
                r_sen <= i_sensed;
                r_stp <= i_step_time;
            end
            OP_ERR: begin
                r_err   <= sat_w(WD'(r_tgt) - WD'(r_sen));
                r_delta <= sat_w(WD'(r_sen) - WD'(r_lsen));
                r_den   <= (W+1)'({r_tau, 1'b0}) + (W+1)'(r_stp);
                r_k     <= $signed((W+1)'({r_tau, 1'b0})) - $signed((W+1)'(r_stp));
            end
            OP_MP, OP_MI, OP_MD: r_prod <= prod_c;
            OP_P: begin
                r_prop <= sat_w(sh_f);
                r_prod <= prod_c;
            end
            OP_T: begin
                // symmetric clamp of the integral step factor
                if (tv > VMAX_X) begin
                    r_t <= VMAX_X[W-1:0];
                end else if (tv < -VMAX_X) begin
                    r_t <= VMIN_X[W-1:0] + 1'b1;
                end else begin
                    r_t <= tv[W-1:0];
                end
            end
            OP_ACC: begin
                r_acc <= WD'(r_integ) + sh_f1;
                r_hi  <= (omax_x > prop_x) ? omax_x - prop_x : '0;
                r_lo  <= (omin_x < prop_x) ? omin_x - prop_x : '0;
            end
            OP_M1: begin
                r_num  <= -(sh_f <<< 1);
                r_prod <= prod_c;
            end
            OP_NUM: r_num <= r_num + sh_f;
            OP_DSET: begin
                r_dvd <= num_shl[DV-1:0];
                r_dvs <= r_den;
                r_rem <= '0;
                r_neg <= r_num[WD-1];
            end
            OP_DIV: begin
                r_rem <= rem_nx[DW-1:0];
                r_dvd <= {r_dvd[DV-2:0], ge};
            end
            OP_SUM: r_y <= ys[W-1:0];
            OP_MY: begin
                r_prod <= prod_c;
                r_add  <= y_pos ? $signed({2'b00, r_dbp}) : -$signed({2'b00, r_dbn});
            end
            OP_DSET2: begin
                r_dvd <= DV'($unsigned(prod_mag));
                r_dvs <= y_pos ? DW'(r_omax) : DW'(-omin_x);
                r_rem <= '0;
                r_neg <= r_prod[2*W+1] ^ !y_pos;
            end
            OP_FIN: r_drive <= o_stat.remap ? sat_w(quo_s + WD'(r_add)) : r_y;
            default: ;
        endcase
    end

    assign o_stat.den_zero = (r_den == '0);
    assign o_stat.div_last = (r_cnt == CW'(1));
    assign o_stat.remap    = (y_pos && (r_omax != '0)) || y_neg;
    assign o_drive         = r_drive;

endmodule

/* sv/pid_controller_filtered_derivative.sv */
// PID controller, trapezoidal integrator with anti-windup clamp, filtered
// derivative on the measurement, output saturation and deadband remap.
// Each accepted word (target, sensed, step_time) yields one drive word.
// Target, sensed, drive and gains are signed fixed point, DATA_WIDTH
// bits with FRAC_BITS fraction bits; step_time is unsigned. The serial
// restoring divider, one quotient bit per cycle, runs once for the
// derivative filter and once for the deadband remap; the filter division
// is skipped when the derivative denominator is zero, and the remap
// product and division when no remap applies. The products, six at most,
// go through one shared multiplier, one per cycle. One sample is in
// flight at a time; o_stall is low only while idle. The result sits in an
// output register, so the next word is taken while the previous result
// still waits. Configuration writes are for the user to make only while
// idle; the block itself does not enforce it. Indexes: 0 gain_prop,
// 1 gain_integ, 2 gain_deriv, 3 filter_tau, 4 out_min, 5 out_max,
// 6 deadband_pos, 7 deadband_neg, all reset to 0.
// depends on pidfd_pkg, pidfd_ctrl, pidfd_dp
`timescale 1ns / 1ps

module pid_controller_filtered_derivative
    import pidfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data,
    // input word
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_target,
    input  logic signed [DATA_WIDTH-1:0] i_sensed,
    input  logic [DATA_WIDTH-2:0]        i_step_time,
    // result word
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_drive
);

    t_op      op;    // per-cycle datapath command
    t_dp_stat stat;  // divider and branch status back to the sequencer

    // sequencer: handshakes and the step order of one sample
    pidfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_op    (op)
    );

    // datapath: config, loop state, multiplier, divider, output register
    pidfd_dp #(
        .W (DATA_WIDTH),
        .F (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_target    (i_target),
        .i_sensed    (i_sensed),
        .i_step_time (i_step_time),
        .i_op        (op),
        .o_stat      (stat),
        .o_drive     (o_drive)
    );

endmodule

/* sv/pidfd_chk.sv */
// port-level checker for the pid controller, bound to the top level
// depends on pid_controller_filtered_derivative_macros.svh
`timescale 1ns / 1ps
`include "pid_controller_filtered_derivative_macros.svh"

module pidfd_chk #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [DATA_WIDTH-1:0] o_drive
);

    // one sample at a time: busy right after an accept
    `PIDFD_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)

    // a new result only appears at the end of a busy period
    `PIDFD_ASSERT_NOW(a_result_from_work, $rose(o_valid), $past(o_stall))

    // a result only appears when the block goes idle
    `PIDFD_ASSERT_NOW(a_result_goes_idle, $rose(o_valid), !o_stall)

    // a held result stays put
    `PIDFD_ASSERT_NEXT(a_hold_result, o_valid && i_stall, o_valid && $stable(o_drive))

endmodule

bind pid_controller_filtered_derivative pidfd_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pidfd_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_drive (o_drive)
);
